### hw/rtl/jac_pkg.sv
package jac_pkg;

  // Channel and sample geometry.
  localparam int NumChannels = 4;
  localparam int ChanW       = 2;
  localparam int RawW        = 10;
  localparam int ValW        = 8;
  localparam int CfgIdxW     = 4;

  // Difference of sample (inverted on some channels) and offset, one sign bit over the raw width.
  localparam int DiffW = RawW + 1;
  // Positive difference times 255 fits in 18 bits.
  localparam int NumW  = RawW + 8;
  localparam int CntW  = $clog2(NumW);

  localparam logic [RawW-1:0] RawMax     = 10'd1023;
  localparam logic [NumW-1:0] RejectAbove = 18'd300;
  localparam logic [NumW-1:0] OutMax     = 18'd255;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegOffset0 = 4'd0;
  localparam logic [CfgIdxW-1:0] RegOffset1 = 4'd1;
  localparam logic [CfgIdxW-1:0] RegOffset2 = 4'd2;
  localparam logic [CfgIdxW-1:0] RegOffset3 = 4'd3;
  localparam logic [CfgIdxW-1:0] RegSpan0   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegSpan1   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegSpan2   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSpan3   = 4'd7;

  // Reset calibration; element 0 is channel zero.
  localparam logic [NumChannels-1:0][RawW-1:0] OffsetReset =
    {10'd400, 10'd430, 10'd400, 10'd450};
  localparam logic [NumChannels-1:0][RawW-1:0] SpanReset =
    {10'd200, 10'd200, 10'd200, 10'd150};

  // Depth of the queue between front and back.
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Calibration settings as seen by the front end.
  typedef struct packed {
    logic [NumChannels-1:0][RawW-1:0] offset;
    logic [NumChannels-1:0][RawW-1:0] span;
  } jac_cfg_t;

  // One classified sample waiting for its division.
  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic             force_zero;
    logic [NumW-1:0]  num;
    logic [RawW-1:0]  span;
  } jac_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } jac_state_t;

endpackage

### hw/rtl/jac_if.sv
interface jac_in_if import jac_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface jac_out_if import jac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] axis_channel;
  logic [ValW-1:0]  axis_value;

  modport source (output valid, output axis_channel, output axis_value, input ready);
  modport sink   (input valid, input axis_channel, input axis_value, output ready);
endinterface

interface jac_cfg_if import jac_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RawW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/jac_regs.sv
module jac_regs import jac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  jac_cfg_if.sink       cfg,
  output jac_cfg_t      cfg_o
);

  logic [NumChannels-1:0][RawW-1:0] offset_r, offset_nxt;
  logic [NumChannels-1:0][RawW-1:0] span_r, span_nxt;

  // Writes are always taken; indexes beyond the list are dropped.
  assign cfg.ready = 1'b1;

  always_comb begin
    offset_nxt = offset_r;
    span_nxt   = span_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        RegOffset0: offset_nxt[0] = cfg.data;
        RegOffset1: offset_nxt[1] = cfg.data;
        RegOffset2: offset_nxt[2] = cfg.data;
        RegOffset3: offset_nxt[3] = cfg.data;
        RegSpan0:   span_nxt[0]   = cfg.data;
        RegSpan1:   span_nxt[1]   = cfg.data;
        RegSpan2:   span_nxt[2]   = cfg.data;
        RegSpan3:   span_nxt[3]   = cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OffsetReset;
      span_r   <= SpanReset;
    end else begin
      offset_r <= offset_nxt;
      span_r   <= span_nxt;
    end
  end

  assign cfg_o.offset = offset_r;
  assign cfg_o.span   = span_r;

endmodule

### hw/rtl/jac_front.sv
module jac_front import jac_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  jac_in_if.sink        in_ch,
  input  jac_cfg_t      cfg_i,
  input  logic          q_full,
  output logic          q_push,
  output jac_item_t     q_item
);

  logic [ChanW-1:0] chan_r, chan_nxt;
  logic [RawW-1:0]  sample;
  logic [RawW-1:0]  offset;
  logic [RawW-1:0]  span;
  logic [DiffW-1:0] diff;
  logic [RawW-1:0]  mag;
  logic             positive;

  // A word is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Channels zero and two read inverted.
  assign offset = cfg_i.offset[chan_r];
  assign span   = cfg_i.span[chan_r];
  assign sample = chan_r[0] ? in_ch.raw_sample : (RawMax - in_ch.raw_sample);

  // A difference at or below zero can only give a zero result.
  assign diff     = {1'b0, sample} - {1'b0, offset};
  assign positive = !diff[DiffW-1] && (diff != '0);
  assign mag      = diff[RawW-1:0];

  // Times 255 as a shift and a subtract.
  always_comb begin
    q_item.chan       = chan_r;
    q_item.force_zero = !positive || (span == '0);
    q_item.num        = {mag, 8'd0} - {{(NumW-RawW){1'b0}}, mag};
    q_item.span       = span;
  end

  // Round-robin channel pointer.
  always_comb begin
    chan_nxt = chan_r;
    if (q_push) begin
      if (chan_r >= ChanW'(NumChannels - 1)) begin
        chan_nxt = '0;
      end else begin
        chan_nxt = chan_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
    end else begin
      chan_r <= chan_nxt;
    end
  end

endmodule

### hw/rtl/jac_fifo.sv
module jac_fifo import jac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  jac_item_t push_item,
  input  logic      pop,
  output jac_item_t pop_item,
  output logic      full,
  output logic      empty
);

  jac_item_t             mem_r [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FifoPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FifoCntW-1:0]   count_r, count_nxt;

  assign full     = (count_r == FifoCntW'(FifoDepth));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef NO_ASSERTIONS
  // The front end must never write into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  // The back end must never read an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule

### hw/rtl/jac_back.sv
module jac_back import jac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  jac_item_t q_item,
  output logic      q_pop,
  jac_out_if.source out_ch
);

  jac_state_t        state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [RawW:0]     rem_r, rem_nxt;
  logic [NumW-1:0]   quo_r, quo_nxt;
  logic [RawW-1:0]   span_r;
  logic [ChanW-1:0]  chan_r;
  logic              zero_r;
  logic [RawW:0]     trial;
  logic              fits;
  logic              out_valid_r, out_valid_nxt;
  logic [ChanW-1:0]  out_chan_r;
  logic [ValW-1:0]   out_value_r;
  logic [ValW-1:0]   result;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r[RawW-1:0], quo_r[NumW-1]};
  assign fits  = (trial >= {1'b0, span_r});

  // Zero a forced or rejected quotient and clamp the rest to the output range.
  always_comb begin
    if (zero_r || (quo_r > RejectAbove)) begin
      result = '0;
    end else if (quo_r > OutMax) begin
      result = OutMax[ValW-1:0];
    end else begin
      result = quo_r[ValW-1:0];
    end
  end

  // Sequencer: load, divide one bit per cycle, then wait for the output slot.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_DIV;
          cnt_nxt   = CntW'(NumW - 1);
          rem_nxt   = '0;
          quo_nxt   = q_item.num;
        end
      end
      ST_DIV: begin
        rem_nxt = fits ? (trial - {1'b0, span_r}) : trial;
        quo_nxt = {quo_r[NumW-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (q_pop) begin
      span_r <= q_item.span;
      chan_r <= q_item.chan;
      zero_r <= q_item.force_zero;
    end
    if ((state_r == ST_HOLD) && slot_free) begin
      out_chan_r  <= chan_r;
      out_value_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.axis_channel = out_chan_r;
  assign out_ch.axis_value   = out_value_r;

`ifndef NO_ASSERTIONS
  // A new word appears only right after a finished division.
  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid && !out_ch.ready)) |-> $past(state_r == ST_HOLD))
    else $error("output word not sourced from a finished division");

  // The last division step always leads into the hold state.
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |=> (state_r == ST_HOLD))
    else $error("division did not finish after its last step");
`endif

endmodule

### hw/rtl/joystick_axis_calibrator.sv
// Joystick axis calibrator.
// in_ch carries 10-bit converter samples that arrive in channel order
// 0, 1, 2, 3 and then repeat; the block counts the channel itself.
// out_ch returns one word per sample: the channel and an 8-bit position
// after offset removal and span scaling, 255 at saturation and 0 out of range.
// cfg_ch writes offsets (index 0..3) and spans (index 4..7); other indexes
// are dropped. Write it only while no sample is in flight.
// A sample is classified in the cycle it is taken and queued; the back end
// then runs a one-bit-per-cycle restoring divider of 18 steps; it pops the
// next sample only after the previous word has left its hold state.
// The two-entry queue keeps accepting samples while the divider works, and
// a finished word waits in the output register while the next one divides.
// When the receiver stalls the output word holds, the divider stops in its
// hold state and the queue fills, after which in_ch.ready drops.
// Synchronous reset restores the default calibration, sets the channel
// pointer to 0 and empties the queue and the output register.
module joystick_axis_calibrator import jac_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  jac_in_if.sink     in_ch,
  jac_out_if.source  out_ch,
  jac_cfg_if.sink    cfg_ch
);

  jac_cfg_t  cfg;
  jac_item_t push_item;
  jac_item_t pop_item;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // Calibration registers.
  jac_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  // Channel tracking and numerator preparation.
  jac_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_i  (cfg),
    .q_full (full),
    .q_push (push),
    .q_item (push_item)
  );

  // Queue between classification and division.
  jac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  // Division, clamping and output register.
  jac_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (empty),
    .q_item  (pop_item),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

### tb/sv/joystick_axis_calibrator_tb.sv
`timescale 1ns / 1ps

module joystick_axis_calibrator_tb;
  import jac_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int RawTop        = (1 << RawW) - 1;
  localparam int AxisScale     = 255;
  localparam int AxisReject    = 300;
  localparam int AxisMax       = 255;
  localparam int NumRegs       = 8;
  localparam int NumDirected   = 20;
  localparam int NumPhases     = 14;
  localparam int ItemsPerPhase = 100;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 40;
  localparam int CycleLimit    = 300000;
  // Channels whose samples are inverted before calibration.
  localparam logic [NumChannels-1:0] InvertedMask = 4'b0101;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [ValW-1:0]  value;
  } axis_word_t;

  typedef struct packed {
    logic [RawW-1:0] raw;
    logic            known;
    logic [ValW-1:0] value;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   mismatch_count = 0;

  jac_in_if  in_bus ();
  jac_out_if out_bus ();
  jac_cfg_if cfg_bus ();

  joystick_axis_calibrator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Calibration and channel pointer as the block should hold them.
  logic [RawW-1:0]  cal_offset [NumChannels];
  logic [RawW-1:0]  cal_span   [NumChannels];
  logic [ChanW-1:0] sample_chan;

  // Calibration to be loaded at the start of the next phase.
  logic [RawW-1:0] plan_offset [NumChannels];
  logic [RawW-1:0] plan_span   [NumChannels];

  axis_word_t pending_axis [$];

  bit input_back_to_back  = 1'b0;
  bit output_always_ready = 1'b0;
  bit hold_off_pending    = 1'b0;

  // Reset calibration: channel order 0..3, then extremes and window edges.
  directed_row_t directed_rows [NumDirected] = '{
    '{10'd1023, 1'b1, 8'd0},
    '{10'd0,    1'b1, 8'd0},
    '{10'd0,    1'b1, 8'd0},
    '{10'd1023, 1'b1, 8'd0},
    '{10'd0,    1'b1, 8'd0},
    '{10'd600,  1'b1, 8'd255},
    '{10'd393,  1'b1, 8'd255},
    '{10'd400,  1'b1, 8'd0},
    '{10'd573,  1'b1, 8'd0},
    '{10'd635,  1'b0, 8'd0},
    '{10'd357,  1'b0, 8'd0},
    '{10'd637,  1'b0, 8'd0},
    '{10'd572,  1'b0, 8'd0},
    '{10'd401,  1'b0, 8'd0},
    '{10'd493,  1'b0, 8'd0},
    '{10'd499,  1'b0, 8'd0},
    '{10'h2AA,  1'b0, 8'd0},
    '{10'h155,  1'b0, 8'd0},
    '{10'h155,  1'b0, 8'd0},
    '{10'h2AA,  1'b0, 8'd0}
  };

  always #(ClkPeriod / 2) clk = ~clk;

  // Cycle count and overall time limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Offset removal, span scaling and clamping of one sample.
  function automatic logic [ValW-1:0] scaled_position(input logic [ChanW-1:0] chan,
                                                      input logic [RawW-1:0] raw);
    int level;
    int num;
    int quot;
    level = int'(raw);
    if (InvertedMask[chan]) begin
      level = int'(RawMax) - level;
    end
    num = (level - int'(cal_offset[chan])) * AxisScale;
    if (cal_span[chan] == '0) begin
      return '0;
    end
    quot = num / int'(cal_span[chan]);
    if (quot < 0 || quot > AxisReject) begin
      return '0;
    end
    if (quot > AxisMax) begin
      return ValW'(AxisMax);
    end
    return ValW'(quot);
  endfunction

  // Mostly samples that land in or near the calibrated window of the channel.
  function automatic logic [RawW-1:0] pick_raw(input logic [ChanW-1:0] chan);
    int reach;
    int target;
    if (cal_span[chan] == '0 || $urandom_range(0, 9) < 3) begin
      return RawW'($urandom_range(0, RawTop));
    end
    reach  = int'(cal_span[chan]) * AxisReject / AxisScale + 4;
    target = int'(cal_offset[chan]) + int'($urandom_range(0, reach)) - 2;
    if (InvertedMask[chan]) begin
      target = int'(RawMax) - target;
    end
    return RawW'(target);
  endfunction

  // Offer one sample and record the word it must produce once accepted.
  task automatic send_sample(input logic [RawW-1:0] raw, input logic known,
                             input logic [ValW-1:0] known_value);
    int gap;
    axis_word_t word;
    gap = input_back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.raw_sample <= raw;
    do @(posedge clk); while (!in_bus.ready);
    word.chan  = sample_chan;
    word.value = known ? known_value : scaled_position(sample_chan, raw);
    pending_axis.push_back(word);
    sample_chan = (sample_chan == ChanW'(NumChannels - 1)) ? '0 : sample_chan + 1'b1;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RawW-1:0] data);
    int gap;
    gap = input_back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      cfg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    // Indexes past the span registers must leave the calibration alone.
    if (idx <= RegOffset3) begin
      cal_offset[ChanW'(idx - RegOffset0)] = data;
    end else if (idx <= RegSpan3) begin
      cal_span[ChanW'(idx - RegSpan0)] = data;
    end
  endtask

  // Write the planned calibration plus one write to an unused index.
  task automatic load_calibration();
    for (int ch = 0; ch < NumChannels; ch++) begin
      write_reg(RegOffset0 + CfgIdxW'(ch), plan_offset[ch]);
      write_reg(RegSpan0 + CfgIdxW'(ch), plan_span[ch]);
    end
    write_reg(CfgIdxW'(NumRegs + $urandom_range(0, 7)), RawW'($urandom_range(0, RawTop)));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_words();
    while (pending_axis.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off on request, field checks.
  initial begin
    int stall;
    axis_word_t want;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = output_always_ready ? 0 : $urandom_range(0, 8);
      if (hold_off_pending) begin
        out_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_pending = 1'b0;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      if (pending_axis.size() == 0) begin
        report_mismatch($sformatf("word on channel %0d with no sample pending",
                                  out_bus.axis_channel));
      end else begin
        want = pending_axis.pop_front();
        if (out_bus.axis_channel !== want.chan) begin
          report_mismatch($sformatf("axis_channel %0d, expected %0d",
                                    out_bus.axis_channel, want.chan));
        end
        if (out_bus.axis_value !== want.value) begin
          report_mismatch($sformatf("axis_value %0d, expected %0d on channel %0d",
                                    out_bus.axis_value, want.value, want.chan));
        end
      end
    end
  end

  // Stimulus: directed rows under the reset calibration, then random phases.
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.raw_sample = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    for (int ch = 0; ch < NumChannels; ch++) begin
      cal_offset[ch] = OffsetReset[ch];
      cal_span[ch]   = SpanReset[ch];
    end
    sample_chan = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDirected; i++) begin
      send_sample(directed_rows[i].raw, directed_rows[i].known, directed_rows[i].value);
    end
    in_bus.valid <= 1'b0;
    wait_all_words();

    for (int phase = 0; phase < NumPhases; phase++) begin
      input_back_to_back  = (phase % 5 == 3);
      output_always_ready = (phase % 5 == 1);
      for (int ch = 0; ch < NumChannels; ch++) begin
        plan_offset[ch] = ($urandom_range(0, 3) == 0) ? RawW'($urandom_range(0, RawTop))
                                                      : RawW'($urandom_range(300, 600));
        plan_span[ch]   = ($urandom_range(0, 3) == 0) ? RawW'($urandom_range(1, RawTop))
                                                      : RawW'($urandom_range(60, 400));
      end
      case (phase)
        0: begin
          // Smallest offsets with the widest span.
          for (int ch = 0; ch < NumChannels; ch++) begin
            plan_offset[ch] = '0;
            plan_span[ch]   = RawW'(RawTop);
          end
        end
        1: begin
          // Largest offsets with the narrowest span.
          for (int ch = 0; ch < NumChannels; ch++) begin
            plan_offset[ch] = RawW'(RawTop);
            plan_span[ch]   = RawW'(1);
          end
        end
        2: begin
          // A zero span forces the value to zero on its channel.
          plan_span[0] = '0;
          plan_span[2] = '0;
        end
        default: begin
        end
      endcase
      load_calibration();
      // Long receiver hold-off while samples keep coming back to back.
      if (phase % 5 == 3) begin
        hold_off_pending = 1'b1;
      end
      repeat (ItemsPerPhase) send_sample(pick_raw(sample_chan), 1'b0, '0);
      in_bus.valid <= 1'b0;
      wait_all_words();
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_axis.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
